### rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS     = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // One message word on its way from the front end to the compression core
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // final word of the padded message
    } word_entry_t;

    // Round-dependent logic function
    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    // Round-dependent additive constant
    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = K_0;
        end else if (rnd < 7'd40) begin
            k = K_1;
        end else if (rnd < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

### rtl/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// Accepts stream items, packs bytes into big-endian words and appends the
// SHA-1 padding and bit length when a message ends.
// ----------------------------------------------------------------------------
module sha1_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // data_byte
    input  logic                 s_tuser,    // byte_valid
    input  logic                 s_tlast,    // end_of_message
    output logic                 push,
    output sha1_pkg::word_entry_t push_entry,
    input  logic                 fifo_full
);

    typedef enum logic [4:0] {
        F_ACCEPT = 5'b00001,
        F_PAD    = 5'b00010,
        F_ZERO   = 5'b00100,
        F_LEN_HI = 5'b01000,
        F_LEN_LO = 5'b10000
    } front_state_t;

    localparam logic [7:0] PAD_BYTE_W = sha1_pkg::PAD_BYTE;

    front_state_t state_reg, state_next;
    logic [23:0]  acc_reg, acc_next;
    logic [1:0]   byte_cnt_reg, byte_cnt_next;
    logic [3:0]   word_cnt_reg, word_cnt_next;
    logic [63:0]  byte_total_reg, byte_total_next;

    logic        accept;
    logic [63:0] bit_len;
    logic [31:0] pad_word;

    assign s_tready = (state_reg == F_ACCEPT) && !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign bit_len  = {byte_total_reg[60:0], 3'b000};

    // Word holding the tail bytes followed by the pad marker
    always_comb
    begin
        case (byte_cnt_reg)
            2'd0:    pad_word = {PAD_BYTE_W, 24'h0};
            2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE_W, 16'h0};
            2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE_W, 8'h0};
            default: pad_word = {acc_reg[23:0], PAD_BYTE_W};
        endcase
    end

    // Next state and word generation
    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        byte_cnt_next   = byte_cnt_reg;
        word_cnt_next   = word_cnt_reg;
        byte_total_next = byte_total_reg;
        push            = 1'b0;
        push_entry.word = 32'h0;
        push_entry.last = 1'b0;

        unique case (state_reg)
            F_ACCEPT:
            begin
                if (accept) begin
                    if (s_tuser) begin
                        byte_total_next = byte_total_reg + 64'd1;
                        acc_next        = {acc_reg[15:0], s_tdata};
                        byte_cnt_next   = byte_cnt_reg + 2'd1;
                        if (byte_cnt_reg == 2'd3) begin
                            push            = 1'b1;
                            push_entry.word = {acc_reg[23:0], s_tdata};
                            word_cnt_next   = word_cnt_reg + 4'd1;
                        end
                    end
                    if (s_tlast) begin
                        state_next = F_PAD;
                    end
                end
            end
            F_PAD:
            begin
                if (!fifo_full) begin
                    push            = 1'b1;
                    push_entry.word = pad_word;
                    word_cnt_next   = word_cnt_reg + 4'd1;
                    state_next      = (word_cnt_reg == 4'd13) ? F_LEN_HI : F_ZERO;
                end
            end
            F_ZERO:
            begin
                if (word_cnt_reg == 4'd14) begin
                    state_next = F_LEN_HI;
                end else if (!fifo_full) begin
                    push          = 1'b1;
                    word_cnt_next = word_cnt_reg + 4'd1;
                end
            end
            F_LEN_HI:
            begin
                if (!fifo_full) begin
                    push            = 1'b1;
                    push_entry.word = bit_len[63:32];
                    word_cnt_next   = word_cnt_reg + 4'd1;
                    state_next      = F_LEN_LO;
                end
            end
            F_LEN_LO:
            begin
                if (!fifo_full) begin
                    push            = 1'b1;
                    push_entry.word = bit_len[31:0];
                    push_entry.last = 1'b1;
                    word_cnt_next   = 4'd0;
                    byte_cnt_next   = 2'd0;
                    byte_total_next = 64'd0;
                    state_next      = F_ACCEPT;
                end
            end
            default:
            begin
                state_next = F_ACCEPT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= F_ACCEPT;
            byte_cnt_reg   <= 2'd0;
            word_cnt_reg   <= 4'd0;
            byte_total_reg <= 64'd0;
        end else begin
            state_reg      <= state_next;
            byte_cnt_reg   <= byte_cnt_next;
            word_cnt_reg   <= word_cnt_next;
            byte_total_reg <= byte_total_next;
        end
    end

    // Partial word bytes
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

### rtl/sha1_fifo.sv
// ----------------------------------------------------------------------------
// sha1_fifo
// Short word queue between the front end and the compression core.
// ----------------------------------------------------------------------------
module sha1_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sha1_pkg::word_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output sha1_pkg::word_entry_t head,
    output logic                  empty
);

    localparam int PTR_W = $clog2(sha1_pkg::FIFO_DEPTH);

    sha1_pkg::word_entry_t entry_reg [sha1_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = (count_reg == (PTR_W+1)'(sha1_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/sha1_back.sv
// ----------------------------------------------------------------------------
// sha1_back
// Compression core: loads 16 words, runs 80 rounds one per cycle, folds the
// result into the chaining value and streams out the digest.
// ----------------------------------------------------------------------------
module sha1_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha1_pkg::word_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // digest_word, word_index, zero fill
    output logic                  m_tlast    // last_word
);

    typedef enum logic [3:0] {
        B_LOAD   = 4'b0001,
        B_ROUND  = 4'b0010,
        B_UPDATE = 4'b0100,
        B_OUT    = 4'b1000
    } back_state_t;

    back_state_t state_reg;
    logic [3:0]  load_cnt_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        last_reg;

    logic [31:0] w_reg [sha1_pkg::BLOCK_WORDS];
    logic [31:0] chain_reg [sha1_pkg::DIGEST_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [31:0] w_mix, w_new, t_sum;
    logic        out_fire;

    assign pop      = (state_reg == B_LOAD) && !empty;
    assign out_fire = m_tvalid && m_tready;

    // Message schedule and round sum
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign t_sum = {a_reg[26:0], a_reg[31:27]}
                 + sha1_pkg::round_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + w_reg[0] + sha1_pkg::round_k(rnd_reg);

    // Result port
    assign m_tvalid = (state_reg == B_OUT);
    assign m_tdata  = {5'b0, idx_reg, chain_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'(sha1_pkg::DIGEST_WORDS - 1));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= B_LOAD;
            load_cnt_reg <= 4'd0;
            rnd_reg      <= 7'd0;
            idx_reg      <= 3'd0;
            last_reg     <= 1'b0;
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                chain_reg[i] <= sha1_pkg::H_INIT[i];
            end
        end else begin
            unique case (state_reg)
                B_LOAD:
                begin
                    if (pop) begin
                        load_cnt_reg <= load_cnt_reg + 4'd1;
                        if (load_cnt_reg == 4'd15) begin
                            last_reg  <= head.last;
                            rnd_reg   <= 7'd0;
                            state_reg <= B_ROUND;
                        end
                    end
                end
                B_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'(sha1_pkg::ROUNDS - 1)) begin
                        state_reg <= B_UPDATE;
                    end
                end
                B_UPDATE:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    idx_reg      <= 3'd0;
                    state_reg    <= last_reg ? B_OUT : B_LOAD;
                end
                B_OUT:
                begin
                    if (out_fire) begin
                        if (m_tlast) begin
                            idx_reg   <= 3'd0;
                            state_reg <= B_LOAD;
                            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                                chain_reg[i] <= sha1_pkg::H_INIT[i];
                            end
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_LOAD;
                end
            endcase
        end
    end

    // Schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (pop || (state_reg == B_ROUND)) begin
            for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha1_pkg::BLOCK_WORDS-1] <= pop ? head.word : w_new;
        end
        if (pop && (load_cnt_reg == 4'd15)) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (state_reg == B_ROUND) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end
    end

endmodule

### rtl/sha1_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha1_stream_hash_top
// SHA-1 hasher over a byte stream with a streaming in and out interface.
// ----------------------------------------------------------------------------
// Each input item carries an optional byte (tuser set) and an end mark
// (tlast). The front end takes one item per cycle while its four-word queue
// has room and packs bytes into words; the core pops the 16 words of a block
// as they arrive, runs 80 rounds at one per cycle and then folds the result
// into the chaining value. The queue holds only 16 bytes while the rounds
// run, so the other 48 bytes of a block come in during the load. After the
// end mark the front end takes no item until it has queued up to 18 padding
// and length words (which fill out one or two final blocks), then the five
// digest words H0..H4 leave in order, the last one with tlast set, and the
// hasher starts over for the next message.
module sha1_stream_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // byte_valid
    input  logic        s_tlast,    // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // digest_word [31:0], word_index [34:32], zeros
    output logic        m_tlast     // last_word
);

    logic                  push, pop, fifo_full, fifo_empty;
    sha1_pkg::word_entry_t push_entry, head;

    // Byte packing and padding
    sha1_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_entry (push_entry),
        .fifo_full  (fifo_full)
    );

    // Word queue
    sha1_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .empty      (fifo_empty)
    );

    // Compression and digest output
    sha1_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### bench/sha1_stream_hash_top_tb.sv
// ----------------------------------------------------------------------------
// sha1_stream_hash_top_tb
// Self-checking bench for the streaming SHA-1 hasher. Messages of assorted
// lengths go in one item at a time, with no-op items mixed in. A predictor
// in the bench works out the five digest words of each message, and every
// output item is compared with the oldest word still due.
// ----------------------------------------------------------------------------

// One digest word as it should leave the hasher
typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
} digest_word_t;

// Digest predictor and output checker
class sha1_digest_checker;
    logic [31:0]  chain [5];
    logic [7:0]   msg_block [64];
    int unsigned  fill;
    logic [63:0]  byte_count;
    digest_word_t expected_digest [$];
    int           errors;

    function new();
        errors = 0;
        restart();
    endfunction

    // Back to the initial chaining value for a new message
    function void restart();
        foreach (chain[i])
        begin
            chain[i] = sha1_pkg::H_INIT[i];
        end
        foreach (msg_block[i])
        begin
            msg_block[i] = 8'h00;
        end
        fill       = 0;
        byte_count = 64'd0;
    endfunction

    function int pending();
        return expected_digest.size();
    endfunction

    // 80-round compression of msg_block into the chaining value
    function void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wt;
        int          r;
        for (r = 0; r < 16; r++)
        begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 16)
            begin
                wt = w[r];
            end
            else
            begin
                t = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
                wt = {t[30:0], t[31]};
                w[r%16] = wt;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + wt + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // Accepted input item: take the byte, and on an end mark pad and queue the digest
    function void absorb_item(logic [7:0] data, logic has_byte, logic eom);
        logic [63:0]  bit_len;
        digest_word_t dw;
        int           i;
        if (has_byte)
        begin
            msg_block[fill] = data;
            byte_count++;
            fill++;
            if (fill == 64)
            begin
                compress_block();
                fill = 0;
            end
        end
        if (!eom)
        begin
            return;
        end
        msg_block[fill] = sha1_pkg::PAD_BYTE;
        fill++;
        // length no longer fits behind the pad byte: spill into an extra block
        if (fill > 56)
        begin
            for (i = fill; i < 64; i++)
            begin
                msg_block[i] = 8'h00;
            end
            compress_block();
            for (i = 0; i < 56; i++)
            begin
                msg_block[i] = 8'h00;
            end
        end
        else
        begin
            for (i = fill; i < 56; i++)
            begin
                msg_block[i] = 8'h00;
            end
        end
        bit_len = byte_count << 3;
        for (i = 0; i < 8; i++)
        begin
            msg_block[56+i] = bit_len[63-8*i -: 8];
        end
        compress_block();
        for (i = 0; i < 5; i++)
        begin
            dw.word  = chain[i];
            dw.index = 3'(i);
            dw.last  = (i == 4);
            expected_digest.push_back(dw);
        end
        restart();
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // Output item against the oldest expected digest word
    task check_digest_word(logic [39:0] data, logic last);
        digest_word_t dw;
        if (expected_digest.size() == 0)
        begin
            report($sformatf("digest word %h with nothing expected", data));
            return;
        end
        dw = expected_digest.pop_front();
        if (data[31:0] !== dw.word)
        begin
            report($sformatf("H%0d word %h, expected %h", dw.index, data[31:0], dw.word));
        end
        if (data[34:32] !== dw.index)
        begin
            report($sformatf("word index %0d, expected %0d", data[34:32], dw.index));
        end
        if (data[39:35] !== 5'd0)
        begin
            report($sformatf("tdata fill bits %b not zero", data[39:35]));
        end
        if (last !== dw.last)
        begin
            report($sformatf("tlast %b on H%0d, expected %b", last, dw.index, dw.last));
        end
    endtask
endclass

module sha1_stream_hash_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int NOISE_PCT    = 10;
    localparam int PHASE_ITEMS  = 64;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // data_byte
    logic        s_tuser;     // byte_valid
    logic        s_tlast;     // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // digest_word [31:0], word_index [34:32], zeros
    logic        m_tlast;     // last_word

    int                 send_idle;
    int                 recv_idle;
    int                 cycle_count;
    int                 phase_items;
    int                 phase_msgs;
    sha1_digest_checker scoreboard;

    sha1_stream_hash_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Receiver backpressure, changed on the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Output items checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            scoreboard.check_digest_word(m_tdata, m_tlast);
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sha1_stream_hash_top regression: fail");
        $finish;
    end

    // Present one item from a falling edge and hold it until accepted
    task send_item(input logic [7:0] data, input logic has_byte, input logic eom);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= eom;
        forever
        begin
            @(posedge clk);
            if (s_tready)
            begin
                break;
            end
        end
        scoreboard.absorb_item(data, has_byte, eom);
        phase_items++;
        @(negedge clk);
    endtask

    // Random message; the end mark rides on the last byte or on an item of its own
    task send_message(input int len, input bit end_on_byte);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < NOISE_PCT)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
        phase_msgs++;
    endtask

    // Lengths weighted toward short messages and the block and padding boundaries
    task random_phase(input int s_idle, input int r_idle);
        int pick;
        int len;
        send_idle   = s_idle;
        recv_idle   = r_idle;
        phase_items = 0;
        phase_msgs  = 0;
        while (phase_items < PHASE_ITEMS || phase_msgs < 2)
        begin
            pick = $urandom_range(9);
            if (pick < 5)
            begin
                len = $urandom_range(12);
            end
            else if (pick < 8)
            begin
                len = $urandom_range(68, 52);
            end
            else if (pick == 8)
            begin
                len = $urandom_range(132, 116);
            end
            else
            begin
                len = $urandom_range(130);
            end
            // keep the phase near its item budget
            if (phase_items + len > PHASE_ITEMS)
            begin
                len = (phase_items < PHASE_ITEMS) ? PHASE_ITEMS - phase_items : 0;
            end
            send_message(len, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        scoreboard = new();
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        send_idle = 7;
        recv_idle = 81;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: no-op items, empty messages, tiny messages, byte extremes
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);          // empty message
        send_item(8'h61, 1'b1, 1'b0);          // "abc"
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);          // one zero byte, separate end mark
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);          // one 0xff byte
        send_item(8'h5A, 1'b1, 1'b0);          // no-op inside a message
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'hA5, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);          // two empty messages back to back
        send_item(8'h7E, 1'b0, 1'b1);

        random_phase(7, 81);
        random_phase(81, 7);
        random_phase(0, 0);
        s_tvalid <= 1'b0;

        while (scoreboard.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scoreboard.pending() != 0)
        begin
            scoreboard.report($sformatf("%0d digest words never arrived",
                                        scoreboard.pending()));
        end
        if (scoreboard.errors == 0)
        begin
            $display("sha1_stream_hash_top regression: pass");
        end
        else
        begin
            $display("sha1_stream_hash_top regression: fail");
        end
        $finish;
    end
endmodule

### sim.f
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_fifo.sv
rtl/sha1_back.sv
rtl/sha1_stream_hash_top.sv
bench/sha1_stream_hash_top_tb.sv
